### rtl/core/grm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_pkg
// Shared constants, types and state codes of the grid ray march column block.
// ----------------------------------------------------------------------------
package grm_pkg;

	// Map and number formats
	localparam int MAP_WIDTH    = 16;
	localparam int MAP_MAX_ROWS = 16;
	localparam int FRAC_BITS    = 8;
	localparam int DIR_FRAC     = 14;

	// Field widths
	localparam int COL_W   = 8;
	localparam int POS_W   = 12;
	localparam int DIR_W   = 16;
	localparam int DIST_W  = 13;
	localparam int ROWS_W  = 8;
	localparam int STEP_W  = 8;
	localparam int MH_W    = 5;
	localparam int SHADE_W = 2;

	// Map storage: four 64-bit registers of four 16-bit rows each
	localparam int MAP_REG_W   = 64;
	localparam int MAP_REGS    = 4;
	localparam int MAP_STRIDE  = 16;
	localparam int MAP_BITS    = MAP_REG_W * MAP_REGS;
	localparam int MAP_IDX_W   = $clog2(MAP_BITS);
	localparam int CELL_IDX_W  = $clog2(MAP_STRIDE);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = MAP_REG_W;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_A       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_B       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_C       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_D       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RANGE  = 3'd7;

	// Reset values and limits
	localparam logic [MH_W-1:0]   MAP_HEIGHT_RST  = MH_W'(11);
	localparam logic [ROWS_W-1:0] SCREEN_ROWS_RST = ROWS_W'(35);
	localparam logic [STEP_W-1:0] STEP_LENGTH_RST = STEP_W'(26);
	localparam logic [DIST_W-1:0] VIEW_RANGE_RST  = DIST_W'(4096);
	localparam logic [DIST_W-1:0] VR_MIN          = DIST_W'(256);
	localparam logic [DIST_W-1:0] VR_MAX          = DIST_W'(4096);

	// Datapath widths
	localparam int PROD_W   = DIR_W + DIST_W + 1;
	localparam int PX_W     = PROD_W - DIR_FRAC + 2;
	localparam int CELL_W   = PX_W - 1 - FRAC_BITS;
	localparam int NUM_W    = ROWS_W + FRAC_BITS;
	localparam int REM_W    = DIST_W + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Stream payload widths
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;

	typedef struct packed {
		logic [MAP_BITS-1:0] map;
		logic [MH_W-1:0]     map_height;
		logic [ROWS_W-1:0]   screen_rows;
		logic [STEP_W-1:0]   step_length;
		logic [DIST_W-1:0]   view_range;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0]         column;
		logic [POS_W-1:0]         origin_x;
		logic [POS_W-1:0]         origin_y;
		logic signed [DIR_W-1:0]  dir_x;
		logic signed [DIR_W-1:0]  dir_y;
		logic [DIST_W-1:0]        vr;
		logic [STEP_W-1:0]        st;
		logic [MH_W-1:0]          rows_used;
		logic [ROWS_W-1:0]        rows;
	} ray_t;

	typedef struct packed {
		logic               left_map;
		logic [SHADE_W-1:0] shade;
		logic [ROWS_W-1:0]  wall_bottom;
		logic [ROWS_W-1:0]  wall_top;
		logic [DIST_W-1:0]  distance;
		logic [COL_W-1:0]   column_out;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_TEST,
		BK_DIV,
		BK_FIN
	} back_state_t;

endpackage
`default_nettype wire

### rtl/core/grm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_front
// Input stage: takes ray transactions and attaches the sanitized settings.
// ----------------------------------------------------------------------------
module grm_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [grm_pkg::IN_DATA_W-1:0]    in_data,
	input  wire grm_pkg::cfg_t                    cfg,
	output logic                                  push_valid,
	input  wire logic                             push_ready,
	output grm_pkg::ray_t                         push_ray
);
	import grm_pkg::*;

	ray_t ray_s1;
	logic valid_s1;
	ray_t ray_d;

	always_comb begin
		ray_d.column   = in_data[COL_W-1:0];
		ray_d.origin_x = in_data[COL_W +: POS_W];
		ray_d.origin_y = in_data[COL_W+POS_W +: POS_W];
		ray_d.dir_x    = signed'(in_data[COL_W+2*POS_W +: DIR_W]);
		ray_d.dir_y    = signed'(in_data[COL_W+2*POS_W+DIR_W +: DIR_W]);
		if (cfg.view_range < VR_MIN) begin
			ray_d.vr = VR_MIN;
		end else if (cfg.view_range > VR_MAX) begin
			ray_d.vr = VR_MAX;
		end else begin
			ray_d.vr = cfg.view_range;
		end
		ray_d.st = (cfg.step_length == '0) ? STEP_W'(1) : cfg.step_length;
		ray_d.rows_used = (cfg.map_height > MH_W'(MAP_MAX_ROWS)) ?
			MH_W'(MAP_MAX_ROWS) : cfg.map_height;
		ray_d.rows = (cfg.screen_rows == '0) ? ROWS_W'(1) : cfg.screen_rows;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_ray   = ray_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ray_s1 <= ray_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/grm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_queue
// Short FIFO of prepared rays between the input stage and the marcher.
// ----------------------------------------------------------------------------
module grm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire grm_pkg::ray_t push_ray,
	output logic               pop_valid,
	input  wire logic          pop,
	output grm_pkg::ray_t      pop_ray
);
	import grm_pkg::*;

	ray_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = count_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_ray    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_ray;
		end
	end

endmodule
`default_nettype wire

### rtl/core/grm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_back
// Marcher: steps one ray over the wall map, divides for the wall height and
// formats the result into the output register.
// ----------------------------------------------------------------------------
module grm_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output logic                               pop,
	input  wire grm_pkg::ray_t                 pop_ray,
	input  wire logic [grm_pkg::MAP_BITS-1:0]  map,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output grm_pkg::result_t                   res
);
	import grm_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	ray_t                    ray_q;
	logic [DIST_W-1:0]       d_q;
	logic                    left_q;
	logic signed [PROD_W-1:0] prod_x_q;
	logic signed [PROD_W-1:0] prod_y_q;
	logic [NUM_W-1:0]        num_q;
	logic [REM_W-1:0]        rem_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic                    res_valid_q;
	result_t                 res_q;

	// Step test
	logic signed [PROD_W-1:0] off_x;
	logic signed [PROD_W-1:0] off_y;
	logic signed [PX_W-1:0]   px;
	logic signed [PX_W-1:0]   py;
	logic [CELL_W-1:0]        cx;
	logic [CELL_W-1:0]        cy;
	logic                     outside;
	logic                     wall;
	logic [DIST_W:0]          d_sum;
	logic [DIST_W-1:0]        d_next;

	// Divider and result
	logic [REM_W:0]           rem_sh;
	logic                     rem_ge;
	logic [NUM_W-2:0]         half_h;
	logic [ROWS_W-2:0]        mid;
	logic [NUM_W-1:0]         bot_sum;
	logic [ROWS_W-1:0]        rows_m1;
	logic [DIST_W+1:0]        d4;
	logic [DIST_W+1:0]        d2;
	logic [DIST_W+1:0]        vr3;
	result_t                  res_d;
	logic                     fin_load;
	logic                     test_done;

	always_comb begin
		off_x = prod_x_q >>> DIR_FRAC;
		off_y = prod_y_q >>> DIR_FRAC;
		px = PX_W'(off_x) + signed'(PX_W'({1'b0, ray_q.origin_x}));
		py = PX_W'(off_y) + signed'(PX_W'({1'b0, ray_q.origin_y}));
		cx = px[PX_W-2:FRAC_BITS];
		cy = py[PX_W-2:FRAC_BITS];
		// A negative position floors to a negative cell, which is outside.
		outside = px[PX_W-1] || py[PX_W-1] || (cx >= CELL_W'(MAP_WIDTH)) ||
			(cy >= CELL_W'(ray_q.rows_used));
		wall = map[MAP_IDX_W'({cy[CELL_IDX_W-1:0], cx[CELL_IDX_W-1:0]})];
		test_done = outside || wall || (d_q >= ray_q.vr);
		d_sum  = {1'b0, d_q} + (DIST_W+1)'(ray_q.st);
		d_next = (d_sum > {1'b0, ray_q.vr}) ? ray_q.vr : d_sum[DIST_W-1:0];
	end

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		rem_ge = rem_sh >= (REM_W+1)'(d_q);
	end

	always_comb begin
		half_h  = num_q[NUM_W-1:1];
		mid     = ray_q.rows[ROWS_W-1:1];
		rows_m1 = ray_q.rows - 1'b1;
		bot_sum = NUM_W'(mid) + NUM_W'(half_h);
		res_d.column_out = ray_q.column;
		res_d.distance   = d_q;
		res_d.left_map   = left_q;
		if (half_h > (NUM_W-1)'(mid)) begin
			res_d.wall_top = '0;
		end else begin
			res_d.wall_top = ROWS_W'(mid) - ROWS_W'(half_h);
		end
		if (bot_sum > NUM_W'(rows_m1)) begin
			res_d.wall_bottom = rows_m1;
		end else begin
			res_d.wall_bottom = bot_sum[ROWS_W-1:0];
		end
		d4  = {d_q, 2'b00};
		d2  = {1'b0, d_q, 1'b0};
		vr3 = {1'b0, ray_q.vr, 1'b0} + (DIST_W+2)'(ray_q.vr);
		if (d4 < (DIST_W+2)'(ray_q.vr)) begin
			res_d.shade = SHADE_W'(0);
		end else if (d2 < (DIST_W+2)'(ray_q.vr)) begin
			res_d.shade = SHADE_W'(1);
		end else if (d4 < vr3) begin
			res_d.shade = SHADE_W'(2);
		end else begin
			res_d.shade = SHADE_W'(3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					pop     = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_TEST;
			end
			BK_TEST: begin
				state_d = test_done ? BK_DIV : BK_MUL;
			end
			BK_DIV: begin
				if (cnt_q == DIV_CNT_W'(NUM_W-1)) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (!res_valid_q || res_ready) begin
					fin_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				ray_q  <= pop_ray;
				left_q <= 1'b0;
				// The first step never passes the range: step < 256 <= range.
				d_q    <= DIST_W'(pop_ray.st);
			end
			BK_MUL: begin
				prod_x_q <= PROD_W'(ray_q.dir_x) * PROD_W'(signed'({1'b0, d_q}));
				prod_y_q <= PROD_W'(ray_q.dir_y) * PROD_W'(signed'({1'b0, d_q}));
			end
			BK_TEST: begin
				num_q <= {ray_q.rows, FRAC_BITS'(0)};
				rem_q <= '0;
				cnt_q <= '0;
				if (outside) begin
					left_q <= 1'b1;
					d_q    <= ray_q.vr;
				end else if (!test_done) begin
					d_q <= d_next;
				end
			end
			BK_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (rem_ge) begin
					rem_q <= REM_W'(rem_sh - (REM_W+1)'(d_q));
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[REM_W-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

### rtl/core/grid_ray_march_column.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_march_column
// Fixed-step ray marcher for one screen column over a 16x16 wall bit map.
// ----------------------------------------------------------------------------
// Each input transaction is one ray; each produces exactly one result, in
// order. The marcher works on one ray at a time; each march step passes the
// product register, then the cell test. A ray takes at most
// ceil(view_range / step_length) march steps, fewer when a wall or the map
// edge is met first, followed by the load step, a bit-serial division for
// the wall height and the format step into the output register. An input
// register and a two-entry queue let up to three further rays wait while
// one is marched and its result waits in the output register.
// Configuration may only be written while no ray is in flight.
module grid_ray_march_column (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// column, origin_x, origin_y, dir_x, dir_y (lowest bit first)
	input  wire logic [grm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// column_out, distance, wall_top, wall_bottom, shade, left_map
	output logic [grm_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	input  wire logic                              cfg_we,
	input  wire logic [grm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [grm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import grm_pkg::*;

	logic [MAP_REG_W-1:0] map_a_q;
	logic [MAP_REG_W-1:0] map_b_q;
	logic [MAP_REG_W-1:0] map_c_q;
	logic [MAP_REG_W-1:0] map_d_q;
	logic [MH_W-1:0]      map_height_q;
	logic [ROWS_W-1:0]    screen_rows_q;
	logic [STEP_W-1:0]    step_length_q;
	logic [DIST_W-1:0]    view_range_q;
	cfg_t                 cfg;

	logic    push_valid;
	logic    push_ready;
	ray_t    push_ray;
	logic    pop_valid;
	logic    pop;
	ray_t    pop_ray;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_a_q       <= '0;
			map_b_q       <= '0;
			map_c_q       <= '0;
			map_d_q       <= '0;
			map_height_q  <= MAP_HEIGHT_RST;
			screen_rows_q <= SCREEN_ROWS_RST;
			step_length_q <= STEP_LENGTH_RST;
			view_range_q  <= VIEW_RANGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_A:       map_a_q       <= cfg_data;
				CFG_MAP_B:       map_b_q       <= cfg_data;
				CFG_MAP_C:       map_c_q       <= cfg_data;
				CFG_MAP_D:       map_d_q       <= cfg_data;
				CFG_MAP_HEIGHT:  map_height_q  <= cfg_data[MH_W-1:0];
				CFG_SCREEN_ROWS: screen_rows_q <= cfg_data[ROWS_W-1:0];
				CFG_STEP_LENGTH: step_length_q <= cfg_data[STEP_W-1:0];
				CFG_VIEW_RANGE:  view_range_q  <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.map         = {map_d_q, map_c_q, map_b_q, map_a_q};
		cfg.map_height  = map_height_q;
		cfg.screen_rows = screen_rows_q;
		cfg.step_length = step_length_q;
		cfg.view_range  = view_range_q;
	end

	grm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ray   (push_ray)
	);

	grm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ray   (push_ray),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_ray    (pop_ray)
	);

	grm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_ray   (pop_ray),
		.map       (cfg.map),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = OUT_DATA_W'(res);

endmodule
`default_nettype wire

### rtl/core/grm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_checker
// Port-level checks of the grid ray march column block, bound to the top.
// ----------------------------------------------------------------------------
module grm_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [grm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  wire logic                              s_axis_tvalid,
	input  wire logic                              s_axis_tready,
	input  wire logic [grm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  wire logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	input  wire logic                              cfg_we,
	input  wire logic [grm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [grm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import grm_pkg::*;

	result_t res;
	assign res = m_axis_tdata;

	// A result that is not taken stays on the bus unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Distance saturates at the largest view range.
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.distance <= VR_MAX)
		else $error("distance beyond range");

	// Leaving the map forces the full range, hence the farthest shade.
	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.left_map |-> res.shade == SHADE_W'(3) &&
			res.distance >= VR_MIN)
		else $error("left map without full range");

	// The wall span is centered, so the top row never lies below the bottom row.
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.wall_top <= res.wall_bottom)
		else $error("wall top below wall bottom");

endmodule

bind grid_ray_march_column grm_checker u_grm_checker (.*);
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid ray march column block.
// ----------------------------------------------------------------------------
// Rays are pushed through the input stream, first a directed set under a few
// fixed register settings (reset values, a solid map with unit step,
// degenerate zero registers), then random phases under random and extreme
// settings. Each accepted ray is marched again in the bench, and the
// resulting column record is queued. Every column record from the block is
// compared against the oldest queued one. Sender gaps and receiver stalls
// change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
	import grm_pkg::*;

	localparam int  CLK_HALF   = 2;
	localparam int  DIR_SHIFT  = DIR_FRAC;
	localparam real TWO_PI     = 6.283185307179586;

	localparam logic [SHADE_W-1:0] SHADE_NEAR     = 2'd0;
	localparam logic [SHADE_W-1:0] SHADE_MID_NEAR = 2'd1;
	localparam logic [SHADE_W-1:0] SHADE_MID_FAR  = 2'd2;
	localparam logic [SHADE_W-1:0] SHADE_FAR      = 2'd3;

	typedef enum int {
		PACE_FREE,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	// Field order of the input stream, lowest bit last in this list.
	typedef struct packed {
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_x;
		logic [POS_W-1:0]        origin_y;
		logic [POS_W-1:0]        origin_x;
		logic [COL_W-1:0]        column;
	} ray_item_t;

	class column_checker;
		result_t             expected_columns[$];
		int                  errors;
		longint              work_bound;
		logic [MAP_BITS-1:0] walls;
		logic [MH_W-1:0]     mh;
		logic [ROWS_W-1:0]   sr;
		logic [STEP_W-1:0]   sl;
		logic [DIST_W-1:0]   vr_reg;

		function new();
			errors     = 0;
			work_bound = 0;
			walls      = '0;
			mh         = MAP_HEIGHT_RST;
			sr         = SCREEN_ROWS_RST;
			sl         = STEP_LENGTH_RST;
			vr_reg     = VIEW_RANGE_RST;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_MAP_A:       walls[0*MAP_REG_W +: MAP_REG_W] = val;
				CFG_MAP_B:       walls[1*MAP_REG_W +: MAP_REG_W] = val;
				CFG_MAP_C:       walls[2*MAP_REG_W +: MAP_REG_W] = val;
				CFG_MAP_D:       walls[3*MAP_REG_W +: MAP_REG_W] = val;
				CFG_MAP_HEIGHT:  mh = val[MH_W-1:0];
				CFG_SCREEN_ROWS: sr = val[ROWS_W-1:0];
				CFG_STEP_LENGTH: sl = val[STEP_W-1:0];
				CFG_VIEW_RANGE:  vr_reg = val[DIST_W-1:0];
				default: ;
			endcase
		endfunction

		// Marches one ray step by step; the start position at distance zero is never tested.
		function result_t march_ray(ray_item_t r);
			longint  range, stride, used_rows, rows, d;
			longint  ox, oy, dx, dy, px, py, cx, cy, h, mid, top, bot;
			bit      done, left;
			result_t res;
			range = vr_reg;
			if (range < VR_MIN) range = VR_MIN;
			if (range > VR_MAX) range = VR_MAX;
			stride    = (sl == 0) ? 1 : sl;
			used_rows = (mh > MAP_MAX_ROWS) ? MAP_MAX_ROWS : mh;
			rows      = (sr == 0) ? 1 : sr;
			ox = r.origin_x;
			oy = r.origin_y;
			dx = r.dir_x;
			dy = r.dir_y;
			d = 0;
			done = 0;
			left = 0;
			while (!done && d < range) begin
				d += stride;
				if (d > range) d = range;
				px = ox + ((dx * d) >>> DIR_SHIFT);
				py = oy + ((dy * d) >>> DIR_SHIFT);
				cx = px >>> FRAC_BITS;
				cy = py >>> FRAC_BITS;
				if (cx < 0 || cx >= MAP_WIDTH || cy < 0 || cy >= used_rows) begin
					done = 1;
					left = 1;
					d = range;
				end else if (walls[cy * MAP_STRIDE + cx]) begin
					done = 1;
				end
			end
			h   = (rows << FRAC_BITS) / d;
			mid = rows / 2;
			top = mid - h / 2;
			if (top < 0) top = 0;
			bot = mid + h / 2;
			if (bot > rows - 1) bot = rows - 1;
			if (4 * d < range) res.shade = SHADE_NEAR;
			else if (2 * d < range) res.shade = SHADE_MID_NEAR;
			else if (4 * d < 3 * range) res.shade = SHADE_MID_FAR;
			else res.shade = SHADE_FAR;
			res.column_out  = r.column;
			res.distance    = DIST_W'(d);
			res.wall_top    = ROWS_W'(top);
			res.wall_bottom = ROWS_W'(bot);
			res.left_map    = left;
			work_bound += 2 * (range / stride + 2) + 64;
			return res;
		endfunction

		function void log_ray(ray_item_t r);
			expected_columns.push_back(march_ray(r));
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			end
		endfunction

		function void check_column(result_t got);
			result_t want;
			if (expected_columns.size() == 0) begin
				errors++;
				$error("column result %h arrived with no ray outstanding", got);
				return;
			end
			want = expected_columns.pop_front();
			compare_field("column_out", want.column_out, got.column_out);
			compare_field("distance", want.distance, got.distance);
			compare_field("wall_top", want.wall_top, got.wall_top);
			compare_field("wall_bottom", want.wall_bottom, got.wall_bottom);
			compare_field("shade", want.shade, got.shade);
			compare_field("left_map", want.left_map, got.left_map);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	column_checker chk = new();
	pace_t         pace = PACE_FREE;
	longint        cycles = 0;

	grid_ray_march_column i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	always @(negedge clk) begin
		case (pace)
			PACE_RECV_STALL: m_axis_tready <= ($urandom_range(99) >= 48);
			PACE_BOTH:       m_axis_tready <= ($urandom_range(99) >= 34);
			default:         m_axis_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			chk.check_column(result_t'(m_axis_tdata));
	end

	// The allowance grows with every accepted ray by its worst march length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 50000 + 10 * chk.work_bound) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [MAP_REG_W-1:0] wall_pattern();
		logic [MAP_REG_W-1:0] a, b, c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return a & b;
			4:       return a;
			default: return a & b & c;
		endcase
	endfunction

	function automatic ray_item_t make_ray(int col, int ox, int oy, int dx, int dy);
		ray_item_t r;
		r.column   = COL_W'(col);
		r.origin_x = POS_W'(ox);
		r.origin_y = POS_W'(oy);
		r.dir_x    = DIR_W'(dx);
		r.dir_y    = DIR_W'(dy);
		return r;
	endfunction

	// Mostly unit directions starting inside the rows in use; the rest is raw noise.
	function automatic ray_item_t random_ray();
		ray_item_t r;
		real       ang;
		int        used;
		r = {$urandom, $urandom};
		if ($urandom_range(99) < 80) begin
			used = (chk.mh > MAP_MAX_ROWS) ? MAP_MAX_ROWS : chk.mh;
			if (used > 0)
				r.origin_y = POS_W'($urandom_range(0, used * 256 - 1));
			ang = TWO_PI * $urandom_range(0, 65535) / 65536.0;
			r.dir_x = DIR_W'($rtoi($floor(16384.0 * $cos(ang) + 0.5)));
			r.dir_y = DIR_W'($rtoi($floor(16384.0 * $sin(ang) + 0.5)));
		end
		return r;
	endfunction

	task automatic send_ray(input ray_item_t r);
		int gap;
		gap = 0;
		if (pace == PACE_SEND_IDLE)
			while ($urandom_range(99) < 48) gap++;
		else if (pace == PACE_BOTH)
			while ($urandom_range(99) < 34) gap++;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = r;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		chk.log_ray(r);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		chk.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (chk.expected_columns.size() != 0) @(negedge clk);
	endtask

	task automatic pick_setup(input int phase);
		logic [CFG_DATA_W-1:0] step, range, rows, height;
		step   = $urandom_range(16, 255);
		range  = $urandom_range(0, 8191);
		rows   = $urandom_range(0, 255);
		height = ($urandom_range(99) < 80) ? $urandom_range(1, 16) : $urandom_range(0, 31);
		case (phase)
			0: begin
				// Tiny steps are slow, so the range stays short and walls dense.
				step   = $urandom_range(0, 3);
				range  = $urandom_range(0, 400);
				height = MAP_MAX_ROWS;
			end
			1: begin
				step   = 255;
				range  = 8191;
				rows   = 255;
				height = 31;
			end
			2: begin
				step   = 1;
				range  = VR_MIN;
				rows   = 1;
				height = 1;
			end
			3: range = VR_MAX;
			default: ;
		endcase
		write_reg(CFG_MAP_A, wall_pattern());
		write_reg(CFG_MAP_B, wall_pattern());
		write_reg(CFG_MAP_C, (phase == 0) ? {$urandom, $urandom} : wall_pattern());
		write_reg(CFG_MAP_D, wall_pattern());
		write_reg(CFG_MAP_HEIGHT, height);
		write_reg(CFG_SCREEN_ROWS, rows);
		write_reg(CFG_STEP_LENGTH, step);
		write_reg(CFG_VIEW_RANGE, range);
		cfg_we = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tvalid = 1'b0;
		m_axis_tready = 1'b1;
		cfg_we        = 1'b0;
		cfg_index     = CFG_MAP_A;
		cfg_data      = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: empty map, 11 rows, so every ray leaves or runs out.
		send_ray(make_ray(0, 0, 0, 16384, 0));
		send_ray(make_ray(255, 4095, 4095, -16384, 0));
		send_ray(make_ray(17, 2048, 1024, 0, 0));
		send_ray(make_ray(34, 10, 10, -16384, -16384));
		send_ray(make_ray(51, 4095, 0, 16384, 16384));
		send_ray(make_ray(68, 1000, 700, -32768, 32767));
		send_ray(make_ray(85, 3000, 2000, 32767, -32768));
		wait_drained();

		// Solid map with unit step: rays inside hit at the first step, clamped wall rows; two step off the edge.
		write_reg(CFG_MAP_A, '1);
		write_reg(CFG_MAP_B, '1);
		write_reg(CFG_MAP_C, '1);
		write_reg(CFG_MAP_D, '1);
		write_reg(CFG_MAP_HEIGHT, MAP_MAX_ROWS);
		write_reg(CFG_SCREEN_ROWS, 255);
		write_reg(CFG_STEP_LENGTH, 1);
		write_reg(CFG_VIEW_RANGE, 8191);
		cfg_we = 1'b0;
		send_ray(make_ray(1, 12'h880, 12'h880, 16384, 0));
		send_ray(make_ray(2, 0, 0, -16384, 0));
		send_ray(make_ray(3, 0, 0, 0, -1));
		send_ray(make_ray(4, 12'hFFF, 12'h100, 1, 0));
		wait_drained();

		// Zero registers fall back to their minimum meanings.
		write_reg(CFG_MAP_HEIGHT, 0);
		write_reg(CFG_SCREEN_ROWS, 0);
		write_reg(CFG_STEP_LENGTH, 0);
		write_reg(CFG_VIEW_RANGE, 0);
		cfg_we = 1'b0;
		send_ray(make_ray(5, 12'h800, 12'h800, 16384, 16384));
		wait_drained();
		write_reg(CFG_MAP_A, 64'h0000_0000_0000_8001);
		write_reg(CFG_MAP_HEIGHT, 17);
		write_reg(CFG_STEP_LENGTH, 200);
		write_reg(CFG_VIEW_RANGE, 255);
		cfg_we = 1'b0;
		send_ray(make_ray(6, 12'h080, 12'h080, 16384, 0));
		send_ray(make_ray(7, 12'h080, 12'hE80, 0, 16384));
		wait_drained();

		for (int phase = 0; phase < 9; phase++) begin
			pick_setup(phase);
			pace = pace_t'(phase % 4);
			repeat ((phase == 0) ? 80 : 235) send_ray(random_ray());
			wait_drained();
		end

		pace = PACE_FREE;
		repeat (40) @(negedge clk);
		if (chk.errors == 0 && chk.expected_columns.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
